@@ design/cwpd_pkg.sv @@
// shared types and constants for the cross window point dedup block
`default_nettype none

package cwpd_pkg;

    localparam int MAX_KEPT = 64;
    localparam int COORD_W  = 12;
    localparam int OUT_W    = 13;
    localparam int RAD_W    = 8;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);
    localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] REG_OFFSET_X = 2'd0;
    localparam logic [CFG_IW-1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IW-1:0] REG_RADIUS   = 2'd2;

    localparam logic [COORD_W-1:0] OFFSET_X_RST = 12'd1200;
    localparam logic [COORD_W-1:0] OFFSET_Y_RST = 12'd0;
    localparam logic [RAD_W-1:0]   RADIUS_RST   = 8'd20;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture input beat, clear table on first of list
        logic rd;      // read table entry at scan index, advance index
        logic finish;  // write result, store point if kept and room
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_end; // scan index reached fill count
        logic pend;     // a table read is in flight
        logic hit;      // entry read last cycle lies in the window
        logic out_free; // result register can take a beat
    } t_sts;

endpackage

`default_nettype wire

@@ design/cross_window_point_dedup_unit.sv @@
// top level of the cross window point dedup unit
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ------------------------------------
//  point in  input      i_valid / o_ready      i_pos_x, i_pos_y, i_first_of_list
//  result    output     o_valid / i_ready      o_kept, o_out_x, o_out_y, o_table_full
//  config    input      i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// one beat in runs as capture, one read per stored point, a wait for the read data,
// a step to close the scan and a step to write the result;
// a hit ends the scan early
// reset is synchronous active low: config to defaults, table empty, o_ready low
// results sit in an output register, so a new point beat is taken while the
// last result still waits; only a full result register stalls the finish step
`default_nettype none

module cross_window_point_dedup_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [cwpd_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  wire  [cwpd_pkg::COORD_W-1:0]  i_cfg_data,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [cwpd_pkg::COORD_W-1:0]  i_pos_x,
    input  wire  [cwpd_pkg::COORD_W-1:0]  i_pos_y,
    input  wire                           i_first_of_list,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_kept,
    output logic [cwpd_pkg::OUT_W-1:0]    o_out_x,
    output logic [cwpd_pkg::OUT_W-1:0]    o_out_y,
    output logic                          o_table_full
);
    import cwpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle, scan over stored points, finish
    cwpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // table, window compare, offsets and result register
    cwpd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_first_of_list (i_first_of_list),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kept          (o_kept),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_table_full    (o_table_full)
    );

endmodule

`default_nettype wire

@@ design/cwpd_ctrl.sv @@
// controller state machine for the point dedup scan
`default_nettype none

module cwpd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  cwpd_pkg::t_sts   i_sts,
    output cwpd_pkg::t_cmd   o_cmd
);
    import cwpd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd = !i_sts.scan_end && !i_sts.hit;
                if (i_sts.hit || (i_sts.scan_end && !i_sts.pend)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/cwpd_dp.sv @@
// datapath: config registers, point table, window compare and result register
`default_nettype none

module cwpd_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [cwpd_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  wire  [cwpd_pkg::COORD_W-1:0]     i_cfg_data,
    input  wire  [cwpd_pkg::COORD_W-1:0]     i_pos_x,
    input  wire  [cwpd_pkg::COORD_W-1:0]     i_pos_y,
    input  wire                              i_first_of_list,
    input  cwpd_pkg::t_cmd                   i_cmd,
    output cwpd_pkg::t_sts                   o_sts,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_kept,
    output logic [cwpd_pkg::OUT_W-1:0]       o_out_x,
    output logic [cwpd_pkg::OUT_W-1:0]       o_out_y,
    output logic                             o_table_full
);
    import cwpd_pkg::*;

    logic [COORD_W-1:0] r_off_x, r_off_y;
    logic [RAD_W-1:0]   r_radius;

    logic [COORD_W-1:0] r_px, r_py;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_dup;

    logic [2*COORD_W-1:0] r_mem [MAX_KEPT];
    logic [2*COORD_W-1:0] r_rd_data;
    logic                 r_rd_vld;

    logic               r_out_vld, r_kept, r_full;
    logic [OUT_W-1:0]   r_ox, r_oy;

    logic [COORD_W-1:0] qx, qy, dx, dy;
    logic [RAD_W:0]     r2;
    logic               hit;
    logic               room;
    logic               out_free;

    // window test against the entry read last cycle
    always_comb begin
        qx  = r_rd_data[2*COORD_W-1:COORD_W];
        qy  = r_rd_data[COORD_W-1:0];
        dx  = (r_px >= qx) ? (r_px - qx) : (qx - r_px);
        dy  = (r_py >= qy) ? (r_py - qy) : (qy - r_py);
        r2  = {r_radius, 1'b0};
        hit = r_rd_vld && (
                  ((dy == '0) && ({{(COORD_W-RAD_W-1){1'b0}}, r2} >= dx)) ||
                  ((dx == '0) && ({{(COORD_W-RAD_W-1){1'b0}}, r2} >= dy)) ||
                  (({{(COORD_W-RAD_W){1'b0}}, r_radius} >= dx) &&
                   ({{(COORD_W-RAD_W){1'b0}}, r_radius} >= dy)));
    end

    assign room     = (r_count < CNT_W'(MAX_KEPT));
    assign out_free = !r_out_vld || i_ready;

    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.pend     = r_rd_vld;
    assign o_sts.hit      = hit;
    assign o_sts.out_free = out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= OFFSET_X_RST;
            r_off_y  <= OFFSET_Y_RST;
            r_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X: r_off_x  <= i_cfg_data;
                REG_OFFSET_Y: r_off_y  <= i_cfg_data;
                REG_RADIUS:   r_radius <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // scan control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_dup    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_dup <= 1'b0;
                if (i_first_of_list) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit) begin
                r_dup <= 1'b1;
            end
            if (i_cmd.finish && !r_dup && room) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    // point table, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !r_dup && room) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_px, r_py};
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_kept <= !r_dup;
            r_ox   <= r_dup ? '0 : ({1'b0, r_px} + {1'b0, r_off_x});
            r_oy   <= r_dup ? '0 : ({1'b0, r_py} + {1'b0, r_off_y});
            r_full <= !r_dup && !room;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_kept       = r_kept;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_table_full = r_full;

endmodule

`default_nettype wire

@@ tb/cwpd_dedup_checker.sv @@
`timescale 1ns / 100ps
// watches the point and result channels, predicts each dedup verdict and compares

module cwpd_dedup_checker
    import cwpd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [CFG_IW-1:0]  i_cfg_idx,
    input  wire  [COORD_W-1:0] i_cfg_data,
    input  wire                i_pt_valid,
    input  wire                i_pt_ready,
    input  wire  [COORD_W-1:0] i_pos_x,
    input  wire  [COORD_W-1:0] i_pos_y,
    input  wire                i_first_of_list,
    input  wire                i_res_valid,
    input  wire                i_res_ready,
    input  wire                i_kept,
    input  wire  [OUT_W-1:0]   i_out_x,
    input  wire  [OUT_W-1:0]   i_out_y,
    input  wire                i_table_full,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        logic             kept;
        logic [OUT_W-1:0] out_x;
        logic [OUT_W-1:0] out_y;
        logic             table_full;
    } t_point_verdict;

    logic [COORD_W-1:0] off_x = OFFSET_X_RST;
    logic [COORD_W-1:0] off_y = OFFSET_Y_RST;
    logic [RAD_W-1:0]   win_r = RADIUS_RST;

    logic [COORD_W-1:0] seen_x [MAX_KEPT];
    logic [COORD_W-1:0] seen_y [MAX_KEPT];
    int                 seen_cnt = 0;

    t_point_verdict     awaited_verdicts [$];
    int                 err_cnt = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // cross arms of length 2r plus a square box of half width r
    function automatic bit in_cross_window(input int x, input int y, input int qx,
                                           input int qy, input int r);
        int dx;
        int dy;
        dx = (x >= qx) ? x - qx : qx - x;
        dy = (y >= qy) ? y - qy : qy - y;
        if (dy == 0 && dx <= 2 * r)
            return 1'b1;
        if (dx == 0 && dy <= 2 * r)
            return 1'b1;
        return (dx <= r && dy <= r);
    endfunction

    task predict_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                       input logic first);
        t_point_verdict v;
        bit             dup;
        dup = 1'b0;
        v   = '0;
        if (first)
            seen_cnt = 0;
        for (int i = 0; i < seen_cnt; i++) begin
            if (in_cross_window(x, y, seen_x[i], seen_y[i], win_r))
                dup = 1'b1;
        end
        if (!dup) begin
            v.kept  = 1'b1;
            v.out_x = OUT_W'(x) + OUT_W'(off_x);
            v.out_y = OUT_W'(y) + OUT_W'(off_y);
            if (seen_cnt < MAX_KEPT) begin
                seen_x[seen_cnt] = x;
                seen_y[seen_cnt] = y;
                seen_cnt++;
            end else begin
                v.table_full = 1'b1;
            end
        end
        awaited_verdicts = {awaited_verdicts, v};
    endtask

    task check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_point_verdict head;
        if (!i_rst_n) begin
            off_x    = OFFSET_X_RST;
            off_y    = OFFSET_Y_RST;
            win_r    = RADIUS_RST;
            seen_cnt = 0;
            awaited_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X: off_x = i_cfg_data;
                    REG_OFFSET_Y: off_y = i_cfg_data;
                    REG_RADIUS:   win_r = i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $display({"%0t: result beat with nothing expected, ",
                              "actual kept=%0d x=%0d y=%0d full=%0d"},
                             $time, i_kept, i_out_x, i_out_y, i_table_full);
                    err_cnt++;
                end else begin
                    head = awaited_verdicts.pop_front();
                    check_field("kept", head.kept, i_kept);
                    check_field("out_x", head.out_x, i_out_x);
                    check_field("out_y", head.out_y, i_out_y);
                    check_field("table_full", head.table_full, i_table_full);
                end
            end
            if (i_pt_valid && i_pt_ready)
                predict_point(i_pos_x, i_pos_y, i_first_of_list);
        end
        o_outstanding <= awaited_verdicts.size();
        o_fail_count  <= err_cnt;
    end

endmodule

@@ tb/tb_cross_window_point_dedup_unit.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the cross window point dedup unit

module tb_cross_window_point_dedup_unit;
    import cwpd_pkg::*;

    localparam int RUN_LIMIT     = 1000000;
    localparam int RANDOM_POINTS = 1250;
    localparam int PHASES        = 8;
    localparam int LONG_HOLD     = 600;
    localparam int DRAIN_CYCLES  = 100;

    // no register lives at this index, writes to it must be dropped
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [CFG_IW-1:0]  i_cfg_idx       = '0;
    logic [COORD_W-1:0] i_cfg_data      = '0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [COORD_W-1:0] i_pos_x         = '0;
    logic [COORD_W-1:0] i_pos_y         = '0;
    logic               i_first_of_list = 1'b0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic               o_kept;
    logic [OUT_W-1:0]   o_out_x;
    logic [OUT_W-1:0]   o_out_y;
    logic               o_table_full;

    int fails;
    int outstanding;

    // radius as the block currently holds it, steers the near point offsets
    int cur_radius = RADIUS_RST;
    // sender burst state
    int burst_left = 0;
    // bumping this asks the result side for one long hold-off
    int hold_req   = 0;
    int cycles     = 0;

    // points of the current list, bases for near and boundary points
    logic [2*COORD_W-1:0] list_pts [$];

    cross_window_point_dedup_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_first_of_list (i_first_of_list),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kept          (o_kept),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_table_full    (o_table_full)
    );

    cwpd_dedup_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pt_valid      (i_valid),
        .i_pt_ready      (o_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_first_of_list (i_first_of_list),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_kept          (o_kept),
        .i_out_x         (o_out_x),
        .i_out_y         (o_out_y),
        .i_table_full    (o_table_full),
        .o_fail_count    (fails),
        .o_outstanding   (outstanding)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog, the only other way out of the run
    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side: stall pattern in random segments, plus long hold-offs on request
    initial begin : result_sink
        int seen;
        int seg;
        int mode;
        int hold;
        seen = 0;
        seg  = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != seen) begin
                seen = hold_req;
                hold = LONG_HOLD;
            end
            if (seg == 0) begin
                mode = $urandom_range(0, 3);
                seg  = $urandom_range(1, 80);
            end
            seg--;
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 5) == 0);
                    default: i_ready <= ~i_ready;
                endcase
            end
        end
    end

    // config writes chain back to back, the enable drops once at the end
    task cfg_write(input logic [CFG_IW-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task cfg_close();
        i_cfg_we <= 1'b0;
    endtask

    // drop valid and wait; n sets how long
    task pause(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // a pause first so the checker has counted the last point beat
    task wait_idle();
        pause(1);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task set_window(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                    input logic [COORD_W-1:0] rdata);
        wait_idle();
        cfg_write(REG_OFFSET_X, ox);
        cfg_write(REG_OFFSET_Y, oy);
        cfg_write(REG_RADIUS, rdata);
        cfg_close();
        cur_radius = rdata[RAD_W-1:0];
    endtask

    // offer one point beat and hold it until taken; valid stays up afterwards
    task send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                    input logic first);
        if (first)
            list_pts.delete();
        list_pts = {list_pts, {x, y}};
        i_valid         <= 1'b1;
        i_pos_x         <= x;
        i_pos_y         <= y;
        i_first_of_list <= first;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // sender bursts with random gaps, sometimes a long stretch with none
    task paced_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                     input logic first);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
                pause(gap);
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
        burst_left--;
        send_point(x, y, first);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > (1 << COORD_W) - 1)
            return '1;
        return COORD_W'(v);
    endfunction

    // offsets that sit on either side of the window borders
    function automatic int border_step(input int r);
        int m;
        case ($urandom_range(0, 5))
            0:       m = 0;
            1:       m = r;
            2:       m = r + 1;
            3:       m = 2 * r;
            4:       m = 2 * r + 1;
            default: m = $urandom_range(0, 2 * r + 2);
        endcase
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    // fresh random point, or a neighbor of one already in the list
    task make_point(input int fresh_pct, output logic [COORD_W-1:0] x,
                    output logic [COORD_W-1:0] y);
        logic [2*COORD_W-1:0] base;
        int                   dx;
        int                   dy;
        if (list_pts.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else begin
            base = list_pts[$urandom_range(0, list_pts.size() - 1)];
            dx   = border_step(cur_radius);
            dy   = border_step(cur_radius);
            // bias toward the arms of the cross
            case ($urandom_range(0, 2))
                0:       dy = 0;
                1:       dx = 0;
                default: ;
            endcase
            x = clamp_coord(int'(base[2*COORD_W-1:COORD_W]) + dx);
            y = clamp_coord(int'(base[COORD_W-1:0]) + dy);
        end
    endtask

    initial begin : stimulus
        int                 phase_sent;
        int                 len;
        bit                 long_list;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               first;
        logic [COORD_W-1:0] rnd_r;

        // synchronous reset, held low before release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused index, nothing may change
        cfg_write(REG_UNUSED, 12'hFFF);
        cfg_close();

        // default window: radius 20, offset 1200 / 0
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0);   // both coordinates at max
        send_point(12'd0, 12'd0, 1'b0);         // exact repeat
        send_point(12'd40, 12'd0, 1'b0);        // end of the horizontal arm
        send_point(12'd0, 12'd40, 1'b0);        // end of the vertical arm
        send_point(12'd20, 12'd20, 1'b0);       // corner of the box
        send_point(12'd41, 12'd0, 1'b0);        // one past the arm
        send_point(12'd2000, 12'd2000, 1'b0);
        send_point(12'd2021, 12'd2020, 1'b0);   // just outside the box
        send_point(12'd2000, 12'd2041, 1'b0);
        send_point(12'd1999, 12'd1980, 1'b0);   // inside the box
        send_point(12'd4095, 12'd4055, 1'b0);   // vertical arm near the max corner
        send_point(12'd4095, 12'd4095, 1'b1);   // new list clears the table
        send_point(12'd0, 12'd0, 1'b0);

        // widest window and largest offsets
        set_window(12'd4095, 12'd4095, 12'h0FF);
        send_point(12'd4095, 12'd4095, 1'b1);
        send_point(12'd4095, 12'd3585, 1'b0);
        send_point(12'd3840, 12'd3840, 1'b0);
        send_point(12'd3839, 12'd4095, 1'b0);
        send_point(12'd3584, 12'd3584, 1'b0);

        // radius zero, only an exact match is a duplicate
        set_window(12'd0, 12'd0, 12'h000);
        send_point(12'd100, 12'd100, 1'b1);
        send_point(12'd100, 12'd100, 1'b0);
        send_point(12'd101, 12'd100, 1'b0);
        send_point(12'd100, 12'd101, 1'b0);
        send_point(12'd4095, 12'd0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            // upper bits of the radius data are don't-care
            case (ph)
                0: set_window(12'd0, 12'd0, {4'hA, 8'd1});
                1: set_window(12'd4095, 12'd4095, {4'h5, 8'd255});
                2: set_window(COORD_W'($urandom), COORD_W'($urandom), {4'($urandom), 8'd0});
                3: set_window(OFFSET_X_RST, OFFSET_Y_RST, {4'($urandom), RADIUS_RST});
                default: begin
                    rnd_r = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                                 : $urandom_range(1, 12));
                    set_window(COORD_W'($urandom), COORD_W'($urandom),
                               {4'($urandom), rnd_r[RAD_W-1:0]});
                end
            endcase

            // long hold-off on the result side while points keep coming
            if (ph == 1 || ph == 5)
                hold_req++;

            phase_sent = 0;
            while (phase_sent < RANDOM_POINTS / PHASES) begin
                // long lists run the table into its full state
                long_list = ($urandom_range(0, 9) < 3);
                len       = long_list ? $urandom_range(66, 100) : $urandom_range(1, 30);
                for (int k = 0; k < len && phase_sent < RANDOM_POINTS / PHASES; k++) begin
                    make_point(long_list ? 85 : 40, px, py);
                    // a stray list start now and then breaks the sequence
                    first = (k == 0) || ($urandom_range(0, 49) == 0);
                    paced_point(px, py, first);
                    phase_sent++;
                end
            end
        end

        // drain, then idle once more before the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ cross_window_point_dedup_unit.f @@
design/cwpd_pkg.sv
design/cwpd_ctrl.sv
design/cwpd_dp.sv
design/cross_window_point_dedup_unit.sv
tb/cwpd_dedup_checker.sv
tb/tb_cross_window_point_dedup_unit.sv
